/* rtl/cau_pkg.sv */
// shared constants, types and helpers of the complex arithmetic unit
package cau_pkg;

  localparam int W  = 16;
  localparam int F  = 8;
  localparam int PW = 2 * W;
  localparam int MW = 2 * W + 2;
  localparam int CW = 3 * W + F;
  localparam int NC = W - 1;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    op_t             op;
    logic            dz;
    logic [W-1:0]    pre_re;
    logic [W-1:0]    pre_im;
    logic            re_neg;
    logic            im_neg;
    logic            re_sat;
    logic            im_sat;
    logic [CW-1:0]   re_rem;
    logic [CW-1:0]   im_rem;
    logic [W-2:0]    re_q;
    logic [W-2:0]    im_q;
    logic [CW-1:0]   dsh;
  } item_t;

  function automatic logic [W-1:0] sat_mag(input logic neg, input logic [MW-1:0] mag);
    logic [MW-1:0] pmax;
    logic [MW-1:0] nmag;
    logic [W-1:0]  res;
    pmax = MW'((MW'(1) << (W - 1)) - MW'(1));
    nmag = MW'(1) << (W - 1);
    if (!neg) begin
      res = (mag > pmax) ? pmax[W-1:0] : mag[W-1:0];
    end else if (mag >= nmag) begin
      res = nmag[W-1:0];
    end else begin
      res = W'(-mag);
    end
    return res;
  endfunction

endpackage

/* rtl/cau_div_cell.sv */
// one restoring division cell: develops one quotient bit for both parts
module cau_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_vld,
  input  cau_pkg::item_t in_item,
  output logic           out_vld,
  output cau_pkg::item_t out_item
);

  cau_pkg::item_t item_next;
  logic           re_take;
  logic           im_take;

  always_comb begin
    item_next = in_item;
    re_take = !in_item.re_sat && (in_item.re_rem >= in_item.dsh);
    im_take = !in_item.im_sat && (in_item.im_rem >= in_item.dsh);
    if (re_take) begin
      item_next.re_rem = in_item.re_rem - in_item.dsh;
    end
    if (im_take) begin
      item_next.im_rem = in_item.im_rem - in_item.dsh;
    end
    item_next.re_q = {in_item.re_q[cau_pkg::W-3:0], re_take};
    item_next.im_q = {in_item.im_q[cau_pkg::W-3:0], im_take};
    item_next.dsh  = in_item.dsh >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

/* rtl/complex_arith_unit.sv */
// top level of the pipelined complex add, subtract, multiply and divide unit
//
//  channel  handshake                payload
//  in       in_valid / in_ready      op, a_re, a_im, b_re, b_im
//  out      out_valid / out_ready    res_re, res_im, div_zero
//
// one transaction per cycle unless the output stalls; the path runs through
// the product stage, the sum stage, W-1 division cells and the output register.
// the whole pipeline holds when the output register is full and not taken.
// reset clears the valid bits only.
module complex_arith_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  op,
  input  logic signed [cau_pkg::W-1:0] a_re,
  input  logic signed [cau_pkg::W-1:0] a_im,
  input  logic signed [cau_pkg::W-1:0] b_re,
  input  logic signed [cau_pkg::W-1:0] b_im,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [cau_pkg::W-1:0] res_re,
  output logic signed [cau_pkg::W-1:0] res_im,
  output logic                        div_zero
);

  logic en;

  // product stage
  logic                          pa_vld;
  cau_pkg::op_t                  pa_op;
  logic signed [cau_pkg::W-1:0]  pa_a, pa_b, pa_c, pa_d;
  logic signed [cau_pkg::PW-1:0] pa_ac, pa_bd, pa_bc, pa_ad, pa_cc, pa_dd;

  // sum stage and cell chain
  logic           vld_c [0:cau_pkg::NC];
  cau_pkg::item_t item_c [0:cau_pkg::NC];
  cau_pkg::item_t sb_next;

  logic signed [cau_pkg::W:0]    s_re, s_im;
  logic signed [cau_pkg::PW:0]   m_re, m_im, n_re, n_im;
  logic [cau_pkg::PW:0]          mm_re, mm_im, nm_re, nm_im;
  logic [cau_pkg::PW:0]          den;
  logic [cau_pkg::CW-1:0]        ns_re, ns_im, den_top;
  logic [cau_pkg::W-1:0]         am_re, am_im;

  logic [cau_pkg::W-1:0]         fin_re, fin_im;
  logic [cau_pkg::MW-1:0]        q_re, q_im;

  assign en       = !(out_valid && !out_ready);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      pa_vld <= 1'b0;
    end else if (en) begin
      pa_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_op <= cau_pkg::op_t'(op);
      pa_a  <= a_re;
      pa_b  <= a_im;
      pa_c  <= b_re;
      pa_d  <= b_im;
      pa_ac <= (cau_pkg::PW)'(a_re * b_re);
      pa_bd <= (cau_pkg::PW)'(a_im * b_im);
      pa_bc <= (cau_pkg::PW)'(a_im * b_re);
      pa_ad <= (cau_pkg::PW)'(a_re * b_im);
      pa_cc <= (cau_pkg::PW)'(b_re * b_re);
      pa_dd <= (cau_pkg::PW)'(b_im * b_im);
    end
  end

  always_comb begin
    sb_next = '0;
    sb_next.op = pa_op;
    if (pa_op == cau_pkg::OP_ADD) begin
      s_re = (cau_pkg::W+1)'(pa_a) + (cau_pkg::W+1)'(pa_c);
      s_im = (cau_pkg::W+1)'(pa_b) + (cau_pkg::W+1)'(pa_d);
    end else begin
      s_re = (cau_pkg::W+1)'(pa_a) - (cau_pkg::W+1)'(pa_c);
      s_im = (cau_pkg::W+1)'(pa_b) - (cau_pkg::W+1)'(pa_d);
    end
    m_re  = (cau_pkg::PW+1)'(pa_ac) - (cau_pkg::PW+1)'(pa_bd);
    m_im  = (cau_pkg::PW+1)'(pa_bc) + (cau_pkg::PW+1)'(pa_ad);
    n_re  = (cau_pkg::PW+1)'(pa_ac) + (cau_pkg::PW+1)'(pa_bd);
    n_im  = (cau_pkg::PW+1)'(pa_bc) - (cau_pkg::PW+1)'(pa_ad);
    mm_re = m_re[cau_pkg::PW] ? (cau_pkg::PW+1)'(-m_re) : m_re;
    mm_im = m_im[cau_pkg::PW] ? (cau_pkg::PW+1)'(-m_im) : m_im;
    nm_re = n_re[cau_pkg::PW] ? (cau_pkg::PW+1)'(-n_re) : n_re;
    nm_im = n_im[cau_pkg::PW] ? (cau_pkg::PW+1)'(-n_im) : n_im;
    den   = (cau_pkg::PW+1)'(unsigned'(pa_cc)) + (cau_pkg::PW+1)'(unsigned'(pa_dd));
    ns_re = (cau_pkg::CW)'(nm_re) << cau_pkg::F;
    ns_im = (cau_pkg::CW)'(nm_im) << cau_pkg::F;
    den_top = (cau_pkg::CW)'(den) << (cau_pkg::W - 1);
    if (pa_op == cau_pkg::OP_MUL) begin
      am_re = cau_pkg::sat_mag(m_re[cau_pkg::PW], (cau_pkg::MW)'(mm_re >> cau_pkg::F));
      am_im = cau_pkg::sat_mag(m_im[cau_pkg::PW], (cau_pkg::MW)'(mm_im >> cau_pkg::F));
    end else begin
      am_re = cau_pkg::sat_mag(s_re[cau_pkg::W],
                               (cau_pkg::MW)'(s_re[cau_pkg::W] ? (cau_pkg::W+1)'(-s_re) : s_re));
      am_im = cau_pkg::sat_mag(s_im[cau_pkg::W],
                               (cau_pkg::MW)'(s_im[cau_pkg::W] ? (cau_pkg::W+1)'(-s_im) : s_im));
    end
    sb_next.pre_re = am_re;
    sb_next.pre_im = am_im;
    sb_next.dz     = (pa_op == cau_pkg::OP_DIV) && (pa_c == '0) && (pa_d == '0);
    sb_next.re_neg = n_re[cau_pkg::PW];
    sb_next.im_neg = n_im[cau_pkg::PW];
    sb_next.re_sat = ns_re >= den_top;
    sb_next.im_sat = ns_im >= den_top;
    sb_next.re_rem = ns_re;
    sb_next.im_rem = ns_im;
    sb_next.dsh    = den_top >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_c[0] <= 1'b0;
    end else if (en) begin
      vld_c[0] <= pa_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_c[0] <= sb_next;
    end
  end

  for (genvar i = 0; i < cau_pkg::NC; i++) begin : g_cell
    cau_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_vld   (vld_c[i]),
      .in_item  (item_c[i]),
      .out_vld  (vld_c[i+1]),
      .out_item (item_c[i+1])
    );
  end

  always_comb begin
    q_re = item_c[cau_pkg::NC].re_sat ? ((cau_pkg::MW)'(1) << (cau_pkg::W - 1))
                                      : (cau_pkg::MW)'(item_c[cau_pkg::NC].re_q);
    q_im = item_c[cau_pkg::NC].im_sat ? ((cau_pkg::MW)'(1) << (cau_pkg::W - 1))
                                      : (cau_pkg::MW)'(item_c[cau_pkg::NC].im_q);
    if (item_c[cau_pkg::NC].op != cau_pkg::OP_DIV) begin
      fin_re = item_c[cau_pkg::NC].pre_re;
      fin_im = item_c[cau_pkg::NC].pre_im;
    end else if (item_c[cau_pkg::NC].dz) begin
      fin_re = '0;
      fin_im = '0;
    end else begin
      fin_re = cau_pkg::sat_mag(item_c[cau_pkg::NC].re_neg, q_re);
      fin_im = cau_pkg::sat_mag(item_c[cau_pkg::NC].im_neg, q_im);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld_c[cau_pkg::NC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re   <= fin_re;
      res_im   <= fin_im;
      div_zero <= item_c[cau_pkg::NC].dz;
    end
  end

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_zero |-> res_re == '0 && res_im == '0)
    else $error("divide by zero result not cleared");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("pipeline held without a blocked output");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res_re) && $stable(res_im))
    else $error("output changed while stalled");

endmodule
